// ===== hw/rtl/quaternion_multiply_rotate_macros.svh =====
// assertion macros shared by the quaternion block
`ifndef QUATERNION_MULTIPLY_ROTATE_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QMR_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qmr check failed");
// next-cycle implication
`define QMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qmr check failed");
`else
`define QMR_ASSERT(label, clk, rst, ante, cons)
`define QMR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/qmr_pkg.sv =====
`timescale 1ns / 1ps

package qmr_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int COMP_W      = 16;
  localparam int OPND_W      = COMP_W + 1;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_PRODUCT = 1'b0,
    OP_ROTATE  = 1'b1
  } op_t;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [OPND_W-1:0] opnd_t;

  // one decoded item as it sits in the queue
  typedef struct packed {
    op_t   op;
    comp_t ax;
    comp_t ay;
    comp_t az;
    comp_t aw;
    comp_t bx;
    comp_t by;
    comp_t bz;
    comp_t bw;
  } item_t;

  // data that rides along the product pipeline
  typedef struct packed {
    op_t   op;
    comp_t ax;
    comp_t ay;
    comp_t az;
    comp_t aw;
    comp_t tx;
    comp_t ty;
    comp_t tz;
    comp_t tw;
    logic  tsat;
  } side_t;

endpackage

// ===== hw/rtl/quaternion_multiply_rotate.sv =====
// quaternion product and vector rotation, Q1.14 fixed point
// an item is taken at a rising edge where start is high and busy is low;
// cmd, a_x..a_w and b_x..b_w are sampled at that edge
// cmd 0 returns the hamilton product a*b, cmd 1 rotates b.xyz by a as
// a*v*conj(a) with r_w = 0 (a is meant to be a unit quaternion)
// every component is rounded to nearest, ties up, and clipped to 16 bits;
// saturated reports any clip, including the intermediate a*v of a rotation
// each result shows on r_x..r_w and saturated for exactly one cycle, marked
// by done
// throughput: one item per clock, both commands use the same fixed pipeline
// (front register, two-entry queue, two 3-stage product passes, output reg)
// the receiver cannot stall, so the queue drains every cycle and busy stays
// low in practice; it guards the front register should the queue fill
// synchronous reset clears front valid, queue pointers, pipeline valids and
// done; items in flight at reset are dropped, data registers are not cleared
`timescale 1ns / 1ps

module quaternion_multiply_rotate import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  logic  cmd,
  input  comp_t a_x,
  input  comp_t a_y,
  input  comp_t a_z,
  input  comp_t a_w,
  input  comp_t b_x,
  input  comp_t b_y,
  input  comp_t b_z,
  input  comp_t b_w,
  output logic  done,
  output comp_t r_x,
  output comp_t r_y,
  output comp_t r_z,
  output comp_t r_w,
  output logic  saturated
);

  // front to queue
  logic  push;
  item_t push_item;
  logic  full;

  // queue to back end
  logic  pop;
  item_t pop_item;

  // front: takes the item, decodes the command, zeroes b.w for a rotation
  qmr_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .a_x   (a_x),
    .a_y   (a_y),
    .a_z   (a_z),
    .a_w   (a_w),
    .b_x   (b_x),
    .b_y   (b_y),
    .b_z   (b_z),
    .b_w   (b_w),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .item  (push_item)
  );

  // short queue that decouples the front from the arithmetic
  qmr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // back end: two chained hamilton product passes and the result register
  qmr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop),
    .item      (pop_item),
    .done      (done),
    .r_x       (r_x),
    .r_y       (r_y),
    .r_z       (r_z),
    .r_w       (r_w),
    .saturated (saturated)
  );

endmodule

// ===== hw/rtl/qmr_front.sv =====
`timescale 1ns / 1ps

module qmr_front import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  cmd,
  input  comp_t a_x,
  input  comp_t a_y,
  input  comp_t a_z,
  input  comp_t a_w,
  input  comp_t b_x,
  input  comp_t b_y,
  input  comp_t b_z,
  input  comp_t b_w,
  input  logic  full,
  output logic  busy,
  output logic  push,
  output item_t item
);

  logic  front_valid;
  logic  front_valid_next;
  logic  accept;
  op_t   op_dec;

  assign busy   = front_valid & full;
  assign push   = front_valid & ~full;
  assign accept = start & ~busy;
  assign op_dec = op_t'(cmd);

  assign front_valid_next = accept | (front_valid & full);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  // rotate takes b as a pure vector
  always_ff @(posedge clk) begin
    if (accept) begin
      item.op <= op_dec;
      item.ax <= a_x;
      item.ay <= a_y;
      item.az <= a_z;
      item.aw <= a_w;
      item.bx <= b_x;
      item.by <= b_y;
      item.bz <= b_z;
      item.bw <= (op_dec == OP_ROTATE) ? '0 : b_w;
    end
  end

endmodule

// ===== hw/rtl/qmr_queue.sv =====
`timescale 1ns / 1ps
`include "quaternion_multiply_rotate_macros.svh"

module qmr_queue import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop,
  output item_t pop_item
);

  item_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;

  // the back end never stalls, so the head leaves whenever present
  assign pop      = (count != '0);
  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_item = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  `QMR_ASSERT(a_cnt_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `QMR_ASSERT(a_no_push_full, clk, rst, push, !full)
  `QMR_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - QCNT_W'(1))

endmodule

// ===== hw/rtl/qmr_qmul.sv =====
`timescale 1ns / 1ps

module qmr_qmul import qmr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  opnd_t      p [4],
  input  opnd_t      q [4],
  input  side_t      in_side,
  output logic       out_valid,
  output comp_t      r [4],
  output logic [3:0] sat,
  output side_t      out_side
);

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] CMAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] CMIN = SUM_W'(-32768);

  logic signed [PROD_W-1:0] prod      [16];
  logic signed [PROD_W-1:0] prod_next [16];
  logic signed [SUM_W-1:0]  sum       [4];
  logic signed [SUM_W-1:0]  sum_next  [4];
  logic signed [SUM_W-1:0]  shifted   [4];
  comp_t                    r_next    [4];
  logic [3:0]               sat_next;
  logic                     v1;
  logic                     v2;
  side_t                    s1;
  side_t                    s2;

  // stage 1: all sixteen partial products, index p*4+q
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_next[i*4+j] = p[i] * q[j];
      end
    end
  end

  // stage 2: hamilton sums with the rounding half already added
  always_comb begin
    sum_next[0] = SUM_W'(prod[3]) + SUM_W'(prod[6]) - SUM_W'(prod[9])
                + SUM_W'(prod[12]) + HALF;
    sum_next[1] = SUM_W'(prod[7]) + SUM_W'(prod[8]) + SUM_W'(prod[13])
                - SUM_W'(prod[2]) + HALF;
    sum_next[2] = SUM_W'(prod[1]) - SUM_W'(prod[4]) + SUM_W'(prod[11])
                + SUM_W'(prod[14]) + HALF;
    sum_next[3] = SUM_W'(prod[15]) - SUM_W'(prod[0]) - SUM_W'(prod[5])
                - SUM_W'(prod[10]) + HALF;
  end

  // stage 3: floor shift and clip to 16 bits
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shifted[k] = sum[k] >>> FRAC_BITS;
      if (shifted[k] > CMAX) begin
        r_next[k]   = comp_t'(CMAX[COMP_W-1:0]);
        sat_next[k] = 1'b1;
      end else if (shifted[k] < CMIN) begin
        r_next[k]   = comp_t'(CMIN[COMP_W-1:0]);
        sat_next[k] = 1'b1;
      end else begin
        r_next[k]   = shifted[k][COMP_W-1:0];
        sat_next[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    prod     <= prod_next;
    sum      <= sum_next;
    r        <= r_next;
    sat      <= sat_next;
    s1       <= in_side;
    s2       <= s1;
    out_side <= s2;
  end

endmodule

// ===== hw/rtl/qmr_back.sv =====
`timescale 1ns / 1ps
`include "quaternion_multiply_rotate_macros.svh"

module qmr_back import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t item,
  output logic  done,
  output comp_t r_x,
  output comp_t r_y,
  output comp_t r_z,
  output comp_t r_w,
  output logic  saturated
);

  opnd_t      p1 [4];
  opnd_t      q1 [4];
  side_t      side1_in;
  logic       mid_valid;
  comp_t      t [4];
  logic [3:0] sat1;
  side_t      side1;

  opnd_t      p2 [4];
  opnd_t      q2 [4];
  side_t      side2_in;
  logic       fin_valid;
  comp_t      r2 [4];
  logic [3:0] sat2;
  side_t      fin_side;

  // first pass: a * b (b.w already zero for rotate)
  assign p1[0] = opnd_t'(item.ax);
  assign p1[1] = opnd_t'(item.ay);
  assign p1[2] = opnd_t'(item.az);
  assign p1[3] = opnd_t'(item.aw);
  assign q1[0] = opnd_t'(item.bx);
  assign q1[1] = opnd_t'(item.by);
  assign q1[2] = opnd_t'(item.bz);
  assign q1[3] = opnd_t'(item.bw);

  always_comb begin
    side1_in      = '0;
    side1_in.op   = item.op;
    side1_in.ax   = item.ax;
    side1_in.ay   = item.ay;
    side1_in.az   = item.az;
    side1_in.aw   = item.aw;
  end

  qmr_qmul u_pass1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .p         (p1),
    .q         (q1),
    .in_side   (side1_in),
    .out_valid (mid_valid),
    .r         (t),
    .sat       (sat1),
    .out_side  (side1)
  );

  // second pass: t * conj(a), negation at 17 bits
  assign p2[0] = opnd_t'(t[0]);
  assign p2[1] = opnd_t'(t[1]);
  assign p2[2] = opnd_t'(t[2]);
  assign p2[3] = opnd_t'(t[3]);
  assign q2[0] = -opnd_t'(side1.ax);
  assign q2[1] = -opnd_t'(side1.ay);
  assign q2[2] = -opnd_t'(side1.az);
  assign q2[3] = opnd_t'(side1.aw);

  always_comb begin
    side2_in      = side1;
    side2_in.tx   = t[0];
    side2_in.ty   = t[1];
    side2_in.tz   = t[2];
    side2_in.tw   = t[3];
    side2_in.tsat = |sat1;
  end

  qmr_qmul u_pass2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .p         (p2),
    .q         (q2),
    .in_side   (side2_in),
    .out_valid (fin_valid),
    .r         (r2),
    .sat       (sat2),
    .out_side  (fin_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_valid;
    end
  end

  // final w of a rotation is dropped, so is its clip flag
  always_ff @(posedge clk) begin
    unique case (fin_side.op)
      OP_ROTATE: begin
        r_x       <= r2[0];
        r_y       <= r2[1];
        r_z       <= r2[2];
        r_w       <= '0;
        saturated <= fin_side.tsat | (|sat2[2:0]);
      end
      OP_PRODUCT: begin
        r_x       <= fin_side.tx;
        r_y       <= fin_side.ty;
        r_z       <= fin_side.tz;
        r_w       <= fin_side.tw;
        saturated <= fin_side.tsat;
      end
      default: begin
        r_x       <= fin_side.tx;
        r_y       <= fin_side.ty;
        r_z       <= fin_side.tz;
        r_w       <= fin_side.tw;
        saturated <= fin_side.tsat;
      end
    endcase
  end

  `QMR_ASSERT_NEXT(a_rot_w_zero, clk, rst, fin_valid && fin_side.op == OP_ROTATE, r_w == '0)
  `QMR_ASSERT_NEXT(a_tsat_kept, clk, rst, fin_valid && fin_side.tsat, saturated)
  `QMR_ASSERT_NEXT(a_done_follows, clk, rst, !fin_valid, !done)

endmodule

// ===== tb/sv/qmr_result_checker.sv =====
`timescale 1ns / 1ps

module qmr_result_checker import qmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  busy,
  input  logic  cmd,
  input  comp_t a_x,
  input  comp_t a_y,
  input  comp_t a_z,
  input  comp_t a_w,
  input  comp_t b_x,
  input  comp_t b_y,
  input  comp_t b_z,
  input  comp_t b_w,
  input  logic  done,
  input  comp_t r_x,
  input  comp_t r_y,
  input  comp_t r_z,
  input  comp_t r_w,
  input  logic  saturated,
  output int    mismatches,
  output int    pending
);

  // exact sums before rounding
  typedef struct {
    longint x;
    longint y;
    longint z;
    longint w;
  } exact_quat_t;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
    logic  sat;
  } quat_result_t;

  quat_result_t expected_results[$];
  quat_result_t want;
  int           err_count = 0;

  assign mismatches = err_count;

  function automatic exact_quat_t hamilton_sums(exact_quat_t p, exact_quat_t q);
    exact_quat_t s;
    s.x =  p.x * q.w + p.y * q.z - p.z * q.y + p.w * q.x;
    s.y = -p.x * q.z + p.y * q.w + p.z * q.x + p.w * q.y;
    s.z =  p.x * q.y - p.y * q.x + p.z * q.w + p.w * q.z;
    s.w = -p.x * q.x - p.y * q.y - p.z * q.z + p.w * q.w;
    return s;
  endfunction

  // round to nearest with ties up, then clip to 16 bits
  function automatic comp_t round_clip(longint s, inout logic clip);
    longint r;
    r = (s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > 32767) begin
      clip = 1'b1;
      r = 32767;
    end else if (r < -32768) begin
      clip = 1'b1;
      r = -32768;
    end
    return comp_t'(r);
  endfunction

  function automatic quat_result_t predict_quat_result(item_t it);
    exact_quat_t  a;
    exact_quat_t  b;
    exact_quat_t  t;
    exact_quat_t  ac;
    exact_quat_t  s;
    quat_result_t res;
    logic         clip;
    clip = 1'b0;
    a = '{it.ax, it.ay, it.az, it.aw};
    b = '{it.bx, it.by, it.bz, it.bw};
    if (it.op == OP_PRODUCT) begin
      s = hamilton_sums(a, b);
      res.x = round_clip(s.x, clip);
      res.y = round_clip(s.y, clip);
      res.z = round_clip(s.z, clip);
      res.w = round_clip(s.w, clip);
    end else begin
      // v = (b.xyz, 0), intermediate fully clipped, conj(a) at full precision
      b.w = 0;
      s = hamilton_sums(a, b);
      t.x = round_clip(s.x, clip);
      t.y = round_clip(s.y, clip);
      t.z = round_clip(s.z, clip);
      t.w = round_clip(s.w, clip);
      ac = '{-a.x, -a.y, -a.z, a.w};
      s = hamilton_sums(t, ac);
      res.x = round_clip(s.x, clip);
      res.y = round_clip(s.y, clip);
      res.z = round_clip(s.z, clip);
      res.w = '0;
    end
    res.sat = clip;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    err_count++;
    if (err_count <= 100)
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item pending", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (r_x !== want.x) report_mismatch("r_x", r_x, want.x);
          if (r_y !== want.y) report_mismatch("r_y", r_y, want.y);
          if (r_z !== want.z) report_mismatch("r_z", r_z, want.z);
          if (r_w !== want.w) report_mismatch("r_w", r_w, want.w);
          if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_quat_result(
          '{op_t'(cmd), a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w}));
    end
    pending <= expected_results.size();
  end

endmodule

// ===== tb/sv/quaternion_multiply_rotate_tb.sv =====
`timescale 1ns / 1ps

module quaternion_multiply_rotate_tb;
  import qmr_pkg::*;

  // idle cycles with no item taken and no result seen before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // margin after the drain for a stray late result
  localparam int DRAIN_CYCLES   = 24;
  localparam int RANDOM_ITEMS   = 650;

  localparam comp_t QMAX  = 16'sh7fff;
  localparam comp_t QMIN  = 16'sh8000;
  localparam comp_t ONE   = 16'sd16384;
  localparam comp_t MONE  = -16'sd16384;
  localparam comp_t ZERO  = 16'sd0;
  // cos/sin of 45 degrees, half of a quarter turn
  localparam comp_t HALFQ = 16'sd11585;

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  logic  cmd   = 1'b0;
  comp_t a_x   = '0;
  comp_t a_y   = '0;
  comp_t a_z   = '0;
  comp_t a_w   = '0;
  comp_t b_x   = '0;
  comp_t b_y   = '0;
  comp_t b_z   = '0;
  comp_t b_w   = '0;
  logic  busy;
  logic  done;
  comp_t r_x;
  comp_t r_y;
  comp_t r_z;
  comp_t r_w;
  logic  saturated;
  int    mismatches;
  int    pending;
  int    idle_cycles = 0;
  // items left in a stretch sent back to back
  int    burst_left  = 0;

  always #10 clk = ~clk;

  quaternion_multiply_rotate dut (.*);

  // watches both channels, predicts and compares on its own
  qmr_result_checker result_check (.*);

  // watchdog: any accepted item or result restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // any 16-bit value, weighted toward corners and small magnitudes
  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 6))
          0: return QMIN;
          1: return QMAX;
          2: return ZERO;
          3: return -16'sd1;
          4: return 16'sd1;
          5: return ONE;
          default: return MONE;
        endcase
      end
      2, 3: return comp_t'($urandom_range(0, 16384) - 8192);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // mostly unit quaternions (the intended use), the rest raw operands
  function automatic item_t random_item();
    item_t it;
    real   qx;
    real   qy;
    real   qz;
    real   qw;
    real   norm;
    it.op = op_t'($urandom_range(0, 1));
    it.bx = rand_comp();
    it.by = rand_comp();
    it.bz = rand_comp();
    it.bw = rand_comp();
    if ($urandom_range(0, 9) < 6) begin
      qx = real'(int'($urandom_range(0, 65535)) - 32768);
      qy = real'(int'($urandom_range(0, 65535)) - 32768);
      qz = real'(int'($urandom_range(0, 65535)) - 32768);
      qw = real'(int'($urandom_range(0, 65535)) - 32768);
      norm = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw);
      if (norm < 1.0) begin
        qw = 1.0;
        norm = 1.0;
      end
      it.ax = comp_t'(int'(qx * 16384.0 / norm));
      it.ay = comp_t'(int'(qy * 16384.0 / norm));
      it.az = comp_t'(int'(qz * 16384.0 / norm));
      it.aw = comp_t'(int'(qw * 16384.0 / norm));
    end else begin
      it.ax = rand_comp();
      it.ay = rand_comp();
      it.az = rand_comp();
      it.aw = rand_comp();
    end
    return it;
  endfunction

  task automatic load_fields(item_t it);
    cmd = it.op;
    a_x = it.ax;
    a_y = it.ay;
    a_z = it.az;
    a_w = it.aw;
    b_x = it.bx;
    b_y = it.by;
    b_z = it.bz;
    b_w = it.bw;
  endtask

  // called at a falling edge, returns at a falling edge after the item is taken
  task automatic send_item(item_t it);
    int gap;
    load_fields(it);
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    // random gaps, with the odd back-to-back stretch
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start = 1'b0;
      // junk on the fields while idle, must not be taken
      repeat (gap) begin
        load_fields(random_item());
        @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // products: identity, zeros, full-scale corners
    send_item('{OP_PRODUCT, ZERO, ZERO, ZERO, ONE, QMAX, QMIN, ONE, MONE});
    send_item('{OP_PRODUCT, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    send_item('{OP_PRODUCT, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX});
    send_item('{OP_PRODUCT, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN});
    send_item('{OP_PRODUCT, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN, QMAX, QMIN});
    send_item('{OP_PRODUCT, QMAX, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN, QMIN});
    send_item('{OP_PRODUCT, ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO});
    send_item('{OP_PRODUCT, ZERO, ONE, ZERO, ZERO, ZERO, ZERO, ONE, ZERO});
    // rounding ties: +0.5 lsb goes up, -0.5 lsb goes up toward zero
    send_item('{OP_PRODUCT, ZERO, ZERO, ZERO, 16'sd1, 16'sd8192, ZERO, ZERO, 16'sd8192});
    send_item('{OP_PRODUCT, ZERO, ZERO, ZERO, -16'sd1, 16'sd8192, ZERO, ZERO, 16'sd8192});
    send_item('{OP_PRODUCT, 16'sd3, ZERO, ZERO, -16'sd1, ZERO, ZERO, ZERO, 16'sd8191});
    // rotations: identity, quarter turns about z and x, half turn about y, b_w ignored
    send_item('{OP_ROTATE, ZERO, ZERO, ZERO, ONE, QMAX, QMIN, ONE, QMAX});
    send_item('{OP_ROTATE, ZERO, ZERO, HALFQ, HALFQ, ONE, ZERO, ZERO, QMIN});
    send_item('{OP_ROTATE, HALFQ, ZERO, ZERO, HALFQ, ZERO, ONE, MONE, ONE});
    send_item('{OP_ROTATE, ZERO, ONE, ZERO, ZERO, ONE, ONE, ONE, ZERO});
    // most negative in a, conjugate must not wrap
    send_item('{OP_ROTATE, QMIN, ZERO, ZERO, ZERO, ONE, ONE, MONE, ZERO});
    send_item('{OP_ROTATE, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN});
    // intermediate clips, including its w
    send_item('{OP_ROTATE, QMAX, QMAX, QMAX, ZERO, QMAX, QMAX, QMAX, ZERO});
    send_item('{OP_ROTATE, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX});
    // non-unit a, clipping in both passes, then an all-zero a
    send_item('{OP_ROTATE, ZERO, ZERO, ZERO, QMAX, QMAX, QMIN, ONE, ZERO});
    send_item('{OP_ROTATE, ZERO, ZERO, ZERO, QMIN, QMIN, QMAX, MONE, ZERO});
    send_item('{OP_ROTATE, ZERO, ZERO, ZERO, ZERO, QMAX, QMAX, QMAX, QMAX});

    repeat (RANDOM_ITEMS) send_item(random_item());
    start = 1'b0;

    // let the pipeline drain, then wait a margin for anything stray
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
